[rtl/core/alac_pkg.sv]
// ----------------------------------------------------------------------------
// alac_pkg
// Shared types, constants and helpers for the argmax label accuracy counter.
// ----------------------------------------------------------------------------
package alac_pkg;

  localparam int MaxClasses = 256;
  localparam int ClassW     = (MaxClasses > 1) ? $clog2(MaxClasses) : 1;

  localparam int ScoreW   = 32;
  localparam int LabelW   = 9;
  localparam int OverlapW = 17;
  localparam int KindW    = 2;
  localparam int CountW   = 32;
  localparam int RatioW   = 17;
  localparam int FracW    = 16;
  localparam int StepW    = $clog2(RatioW);

  localparam int ApbAddrW = 4;
  localparam int ApbDataW = 32;

  // input item kinds
  localparam logic [KindW-1:0] KIND_SCORE  = 2'd0;
  localparam logic [KindW-1:0] KIND_CLOSE  = 2'd1;
  localparam logic [KindW-1:0] KIND_FINISH = 2'd2;

  // register indexes (word address)
  localparam logic [1:0] REG_OBJECTNESS = 2'd0;
  localparam logic [1:0] REG_IGN_EN     = 2'd1;
  localparam logic [1:0] REG_IGN_VALUE  = 2'd2;
  localparam logic [1:0] REG_BG_THRESH  = 2'd3;

  localparam logic [LabelW-1:0]   IgnoreValueReset = 9'h1FF;
  localparam logic [OverlapW-1:0] BgThreshReset    = 17'd32768;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_TOTAL,
    ST_DIV_FORE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic              start;
    logic [CountW-1:0] num;
    logic [CountW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [RatioW-1:0] quot;
  } div_rsp_t;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    sat_inc = (&v) ? v : v + CountW'(1);
  endfunction

endpackage

[rtl/core/alac_if.sv]
// ----------------------------------------------------------------------------
// alac_in_if / alac_out_if
// Valid/ready channels for input items and accuracy reports.
// ----------------------------------------------------------------------------
interface alac_in_if;
  logic                               valid;
  logic                               ready;
  logic [alac_pkg::KindW-1:0]         kind;
  logic signed [alac_pkg::ScoreW-1:0] score;
  logic signed [alac_pkg::LabelW-1:0] truth_label;
  logic [alac_pkg::OverlapW-1:0]      truth_overlap;

  modport source (output valid, kind, score, truth_label, truth_overlap, input ready);
  modport sink   (input valid, kind, score, truth_label, truth_overlap, output ready);
endinterface

interface alac_out_if;
  logic                         valid;
  logic                         ready;
  logic [alac_pkg::RatioW-1:0]  accuracy_q16;
  logic                         accuracy_valid;
  logic [alac_pkg::RatioW-1:0]  fore_accuracy_q16;
  logic                         fore_valid;
  logic [alac_pkg::CountW-1:0]  counted_total;
  logic [alac_pkg::CountW-1:0]  counted_fore;

  modport source (output valid, accuracy_q16, accuracy_valid, fore_accuracy_q16, fore_valid,
                  counted_total, counted_fore, input ready);
  modport sink   (input valid, accuracy_q16, accuracy_valid, fore_accuracy_q16, fore_valid,
                  counted_total, counted_fore, output ready);
endinterface

[rtl/core/alac_div.sv]
// ----------------------------------------------------------------------------
// alac_div
// Restoring divider, one quotient bit per cycle: floor(num * 2^16 / den),
// valid for num <= den.
// ----------------------------------------------------------------------------
module alac_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  alac_pkg::div_req_t req_i,
  output alac_pkg::div_rsp_t rsp_o
);

  localparam int RemW = alac_pkg::CountW + 1;

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [alac_pkg::StepW-1:0]  step_q, step_d;
  logic [RemW-1:0]             rem_q, rem_d;
  logic [alac_pkg::CountW-1:0] den_q, den_d;
  logic [alac_pkg::RatioW-1:0] quot_q, quot_d;

  logic [RemW-1:0] trial;
  logic            ge;

  // first step takes the integer bit, no shift
  assign trial = (step_q == '0) ? rem_q : {rem_q[RemW-2:0], 1'b0};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = {1'b0, req_i.num};
      den_d  = req_i.den;
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? trial - {1'b0, den_q} : trial;
      quot_d = {quot_q[alac_pkg::RatioW-2:0], ge};
      if (step_q == alac_pkg::StepW'(alac_pkg::RatioW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + alac_pkg::StepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

[rtl/core/argmax_label_accuracy_counter.sv]
// ----------------------------------------------------------------------------
// argmax_label_accuracy_counter
// Running argmax over class scores and saturating accuracy counters.
// ----------------------------------------------------------------------------
// Score and close transactions leave the input ready: a score updates the
// running argmax (first strictly greater score wins, scores beyond the
// 256th of a location are dropped), a close applies label clipping and the
// skip rules and bumps the saturating counters. A finish transaction runs two
// divisions back to back through one shared bit-serial divider (states
// ST_DIV_TOTAL then ST_DIV_FORE), and the report is loaded into the output
// register from ST_OUT; the input is not ready in those states and is
// ready again once the report is loaded. The report waits in the output
// register until taken. A further finish that completes its divisions
// while the register is still full holds the input off until the register
// frees up. Counters clear when the report is loaded; a pending argmax is
// kept. Registers sit on a small APB port at byte addresses 0, 4, 8, 12 and
// should be written while idle.
module argmax_label_accuracy_counter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  alac_in_if.sink                              in_if,
  alac_out_if.source                           out_if,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [alac_pkg::ApbAddrW-1:0]        paddr,
  input  logic [alac_pkg::ApbDataW-1:0]        pwdata,
  output logic [alac_pkg::ApbDataW-1:0]        prdata,
  output logic                                 pready
);

  localparam int LW = alac_pkg::LabelW;
  localparam int CW = alac_pkg::CountW;
  localparam int RW = alac_pkg::RatioW;

  // config registers
  logic                          obj_q;
  logic                          ign_en_q;
  logic [LW-1:0]                 ign_val_q;
  logic [alac_pkg::OverlapW-1:0] bg_thr_q;

  // argmax state
  logic signed [alac_pkg::ScoreW-1:0] best_score_q, best_score_d;
  logic [alac_pkg::ClassW-1:0]        best_class_q, best_class_d;
  logic                               have_best_q, have_best_d;
  logic [alac_pkg::ClassW-1:0]        class_idx_q, class_idx_d;
  logic                               full_q, full_d;

  // counters
  logic [CW-1:0] total_cnt_q, total_cnt_d;
  logic [CW-1:0] total_hit_q, total_hit_d;
  logic [CW-1:0] fore_cnt_q, fore_cnt_d;
  logic [CW-1:0] fore_hit_q, fore_hit_d;

  // report
  alac_pkg::state_e state_q, state_d;
  logic [RW-1:0]    tot_quot_q, tot_quot_d;
  logic [RW-1:0]    acc_q, acc_d;
  logic             acc_vld_q, acc_vld_d;
  logic [RW-1:0]    fore_acc_q, fore_acc_d;
  logic             fore_vld_q, fore_vld_d;
  logic [CW-1:0]    res_total_q, res_total_d;
  logic [CW-1:0]    res_fore_q, res_fore_d;
  logic             out_vld_q, out_vld_d;
  logic             out_free;

  alac_pkg::div_req_t div_req;
  alac_pkg::div_rsp_t div_rsp;

  logic                 in_acc;
  logic                 cfg_wr;
  logic signed [LW-1:0] label_raw, label_eff, pred;
  logic                 skip;
  logic                 fore;

  alac_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // --------------------------------------------------------------------------
  // APB
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    unique case (paddr[3:2])
      alac_pkg::REG_OBJECTNESS: prdata = {31'd0, obj_q};
      alac_pkg::REG_IGN_EN:     prdata = {31'd0, ign_en_q};
      alac_pkg::REG_IGN_VALUE:  prdata = {{(32-LW){ign_val_q[LW-1]}}, ign_val_q};
      alac_pkg::REG_BG_THRESH:  prdata = {{(32-alac_pkg::OverlapW){1'b0}}, bg_thr_q};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obj_q     <= 1'b0;
      ign_en_q  <= 1'b0;
      ign_val_q <= alac_pkg::IgnoreValueReset;
      bg_thr_q  <= alac_pkg::BgThreshReset;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        alac_pkg::REG_OBJECTNESS: obj_q     <= pwdata[0];
        alac_pkg::REG_IGN_EN:     ign_en_q  <= pwdata[0];
        alac_pkg::REG_IGN_VALUE:  ign_val_q <= pwdata[LW-1:0];
        alac_pkg::REG_BG_THRESH:  bg_thr_q  <= pwdata[alac_pkg::OverlapW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Close decision
  // --------------------------------------------------------------------------
  assign label_raw = in_if.truth_label;
  assign label_eff = (obj_q && (label_raw > 9'sd1)) ? 9'sd1 : label_raw;
  assign pred      = have_best_q ? signed'({1'b0, best_class_q}) : -9'sd1;
  assign fore      = (label_eff != '0);
  assign skip      = (ign_en_q && (label_eff == signed'(ign_val_q))) ||
                     (!fore && (in_if.truth_overlap >= bg_thr_q));

  assign in_if.ready  = (state_q == alac_pkg::ST_IDLE);
  assign in_acc       = in_if.valid & in_if.ready;

  // output register can take a new report this cycle
  assign out_free = !out_vld_q || out_if.ready;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    best_score_d = best_score_q;
    best_class_d = best_class_q;
    have_best_d  = have_best_q;
    class_idx_d  = class_idx_q;
    full_d       = full_q;
    total_cnt_d  = total_cnt_q;
    total_hit_d  = total_hit_q;
    fore_cnt_d   = fore_cnt_q;
    fore_hit_d   = fore_hit_q;
    tot_quot_d   = tot_quot_q;
    acc_d        = acc_q;
    acc_vld_d    = acc_vld_q;
    fore_acc_d   = fore_acc_q;
    fore_vld_d   = fore_vld_q;
    res_total_d  = res_total_q;
    res_fore_d   = res_fore_q;
    out_vld_d    = out_vld_q;
    div_req      = '0;

    if (out_vld_q && out_if.ready) out_vld_d = 1'b0;

    unique case (state_q)
      alac_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_if.kind)
            alac_pkg::KIND_SCORE: begin
              if (!full_q) begin
                if (!have_best_q || (in_if.score > best_score_q)) begin
                  best_score_d = in_if.score;
                  best_class_d = class_idx_q;
                  have_best_d  = 1'b1;
                end
                if (class_idx_q == alac_pkg::ClassW'(alac_pkg::MaxClasses - 1)) begin
                  full_d = 1'b1;
                end else begin
                  class_idx_d = class_idx_q + alac_pkg::ClassW'(1);
                end
              end
            end
            alac_pkg::KIND_CLOSE: begin
              have_best_d = 1'b0;
              class_idx_d = '0;
              full_d      = 1'b0;
              if (!skip) begin
                total_cnt_d = alac_pkg::sat_inc(total_cnt_q);
                if (fore) fore_cnt_d = alac_pkg::sat_inc(fore_cnt_q);
                if (pred == label_eff) begin
                  total_hit_d = alac_pkg::sat_inc(total_hit_q);
                  if (fore) fore_hit_d = alac_pkg::sat_inc(fore_hit_q);
                end
              end
            end
            alac_pkg::KIND_FINISH: begin
              div_req.start = 1'b1;
              div_req.num   = total_hit_q;
              div_req.den   = total_cnt_q;
              state_d       = alac_pkg::ST_DIV_TOTAL;
            end
            default: ;
          endcase
        end
      end
      alac_pkg::ST_DIV_TOTAL: begin
        if (div_rsp.done) begin
          tot_quot_d    = div_rsp.quot;
          div_req.start = 1'b1;
          div_req.num   = fore_hit_q;
          div_req.den   = fore_cnt_q;
          state_d       = alac_pkg::ST_DIV_FORE;
        end
      end
      alac_pkg::ST_DIV_FORE: begin
        if (div_rsp.done) state_d = alac_pkg::ST_OUT;
      end
      alac_pkg::ST_OUT: begin
        // divider holds the foreground quotient until the next start
        if (out_free) begin
          acc_vld_d   = (total_cnt_q != '0);
          acc_d       = (total_cnt_q != '0) ? tot_quot_q : '0;
          fore_vld_d  = (fore_cnt_q != '0);
          fore_acc_d  = (fore_cnt_q != '0) ? div_rsp.quot : '0;
          res_total_d = total_cnt_q;
          res_fore_d  = fore_cnt_q;
          total_cnt_d = '0;
          total_hit_d = '0;
          fore_cnt_d  = '0;
          fore_hit_d  = '0;
          out_vld_d   = 1'b1;
          state_d     = alac_pkg::ST_IDLE;
        end
      end
      default: state_d = alac_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= alac_pkg::ST_IDLE;
      have_best_q <= 1'b0;
      class_idx_q <= '0;
      full_q      <= 1'b0;
      total_cnt_q <= '0;
      total_hit_q <= '0;
      fore_cnt_q  <= '0;
      fore_hit_q  <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      have_best_q <= have_best_d;
      class_idx_q <= class_idx_d;
      full_q      <= full_d;
      total_cnt_q <= total_cnt_d;
      total_hit_q <= total_hit_d;
      fore_cnt_q  <= fore_cnt_d;
      fore_hit_q  <= fore_hit_d;
      out_vld_q   <= out_vld_d;
    end
  end

  // payload, qualified by have_best_q / state_q / out_vld_q
  always_ff @(posedge clk_i) begin
    best_score_q <= best_score_d;
    best_class_q <= best_class_d;
    tot_quot_q   <= tot_quot_d;
    acc_q        <= acc_d;
    acc_vld_q    <= acc_vld_d;
    fore_acc_q   <= fore_acc_d;
    fore_vld_q   <= fore_vld_d;
    res_total_q  <= res_total_d;
    res_fore_q   <= res_fore_d;
  end

  assign out_if.valid             = out_vld_q;
  assign out_if.accuracy_q16      = acc_q;
  assign out_if.accuracy_valid    = acc_vld_q;
  assign out_if.fore_accuracy_q16 = fore_acc_q;
  assign out_if.fore_valid        = fore_vld_q;
  assign out_if.counted_total     = res_total_q;
  assign out_if.counted_fore      = res_fore_q;

endmodule

[dv/alac_checker.sv]
// ----------------------------------------------------------------------------
// alac_checker
// Watches the score/close/finish stream, the report stream and the register
// port, predicts each accuracy report and compares it field by field.
// ----------------------------------------------------------------------------
module alac_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  alac_in_if                            in_mon,
  alac_out_if                           out_mon,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [alac_pkg::ApbAddrW-1:0] paddr,
  input  logic [alac_pkg::ApbDataW-1:0] pwdata,
  output int                            errors_o,
  output int                            pending_o,
  output int                            reports_o
);
  import alac_pkg::*;

  typedef struct packed {
    logic [RatioW-1:0] acc;
    logic              acc_v;
    logic [RatioW-1:0] fore;
    logic              fore_v;
    logic [CountW-1:0] total;
    logic [CountW-1:0] fcount;
  } report_t;

  // register copies
  logic                     cfg_objectness;
  logic                     cfg_ign_en;
  logic signed [LabelW-1:0] cfg_ign_label;
  logic [OverlapW-1:0]      cfg_bg_thresh;

  // running argmax of the open location
  logic signed [ScoreW-1:0] top_score;
  logic [ClassW-1:0]        top_class;
  logic                     have_top;
  int                       scores_taken;

  logic [CountW-1:0] n_total, n_total_hits, n_fore, n_fore_hits;

  report_t expected_reports[$];

  function automatic logic [CountW-1:0] bump(input logic [CountW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [RatioW-1:0] q16_ratio(input logic [CountW-1:0] hits,
                                                  input logic [CountW-1:0] count);
    logic [63:0] num;
    num = {16'b0, hits, 16'b0};
    if (count == 0) return '0;
    return RatioW'(num / {32'b0, count});
  endfunction

  function automatic void clear_argmax();
    top_score    = '0;
    top_class    = '0;
    have_top     = 1'b0;
    scores_taken = 0;
  endfunction

  function automatic void take_score(input logic signed [ScoreW-1:0] s);
    // scores past the last class slot are dropped
    if (scores_taken < MaxClasses) begin
      if (!have_top || s > top_score) begin
        top_score = s;
        top_class = ClassW'(scores_taken);
        have_top  = 1'b1;
      end
      scores_taken++;
    end
  endfunction

  function automatic void close_location(input logic signed [LabelW-1:0] raw_label,
                                         input logic [OverlapW-1:0] overlap);
    int   label;
    int   guess;
    logic drop;
    label = raw_label;
    guess = have_top ? int'(top_class) : -1;
    clear_argmax();
    if (cfg_objectness && label > 1) label = 1;
    drop = (cfg_ign_en && label == int'(cfg_ign_label)) ||
           (label == 0 && overlap >= cfg_bg_thresh);
    if (!drop) begin
      n_total = bump(n_total);
      if (label != 0) n_fore = bump(n_fore);
      // a hit moves only together with its count
      if (guess == label) begin
        n_total_hits = bump(n_total_hits);
        if (label != 0) n_fore_hits = bump(n_fore_hits);
      end
    end
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    report_t want;
    if (!rst_ni) begin
      cfg_objectness = 1'b0;
      cfg_ign_en     = 1'b0;
      cfg_ign_label  = -9'sd1;
      cfg_bg_thresh  = 17'd32768;
      clear_argmax();
      n_total      = '0;
      n_total_hits = '0;
      n_fore       = '0;
      n_fore_hits  = '0;
      expected_reports.delete();
      errors_o  = 0;
      reports_o = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: report with none expected: expected nothing, actual total %0d",
                   $time, out_mon.counted_total);
          errors_o++;
        end else begin
          want = expected_reports.pop_front();
          check_field("accuracy_q16", want.acc, out_mon.accuracy_q16);
          check_field("accuracy_valid", want.acc_v, out_mon.accuracy_valid);
          check_field("fore_accuracy_q16", want.fore, out_mon.fore_accuracy_q16);
          check_field("fore_valid", want.fore_v, out_mon.fore_valid);
          check_field("counted_total", want.total, out_mon.counted_total);
          check_field("counted_fore", want.fcount, out_mon.counted_fore);
        end
        reports_o++;
      end

      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_OBJECTNESS: cfg_objectness = pwdata[0];
          REG_IGN_EN:     cfg_ign_en     = pwdata[0];
          REG_IGN_VALUE:  cfg_ign_label  = pwdata[LabelW-1:0];
          REG_BG_THRESH:  cfg_bg_thresh  = pwdata[OverlapW-1:0];
          default: ;
        endcase
      end

      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.kind)
          KIND_SCORE: take_score(in_mon.score);
          KIND_CLOSE: close_location(in_mon.truth_label, in_mon.truth_overlap);
          KIND_FINISH: begin
            // pending argmax stays, only the counters clear
            want.acc    = q16_ratio(n_total_hits, n_total);
            want.acc_v  = (n_total != 0);
            want.fore   = q16_ratio(n_fore_hits, n_fore);
            want.fore_v = (n_fore != 0);
            want.total  = n_total;
            want.fcount = n_fore;
            expected_reports.push_back(want);
            n_total      = '0;
            n_total_hits = '0;
            n_fore       = '0;
            n_fore_hits  = '0;
          end
          default: ;
        endcase
      end
    end
    pending_o = expected_reports.size();
  end

endmodule

[dv/tb_argmax_label_accuracy_counter.sv]
// ----------------------------------------------------------------------------
// tb_argmax_label_accuracy_counter
// Drives score, close and finish transactions with random gaps and output
// stalls across several register settings; the checker predicts every report.
// ----------------------------------------------------------------------------
module tb_argmax_label_accuracy_counter;
  import alac_pkg::*;

  localparam logic [KindW-1:0] KIND_UNUSED = 2'd3;
  localparam int ItemTarget   = 1250;
  localparam int ReportTarget = 40;
  localparam int CycleLimit   = 500000;
  localparam int SettleCycles = 8;

  logic clk_i;
  logic rst_ni;

  logic                psel, penable, pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  alac_in_if  in_ch ();
  alac_out_if out_ch ();

  int errors, reports_pending, reports_seen;
  int items_sent;
  int phase;
  int cycle_count;
  int hold_req;
  int hold_id;
  bit steady;

  logic                cur_obj, cur_ign_en;
  logic signed [8:0]   cur_ign;
  logic [OverlapW-1:0] cur_thr;

  argmax_label_accuracy_counter dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  alac_checker checker_i (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .errors_o  (errors),
    .pending_o (reports_pending),
    .reports_o (reports_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_argmax_label_accuracy_counter NOT OK");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_class_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 70) return $urandom_range(1, 6);
    if (r < 95) return $urandom_range(7, 20);
    return $urandom_range(21, 40);
  endfunction

  // report side: random back-pressure plus an occasional long hold
  initial begin : report_sink
    int gap_left;
    int hold_left;
    int hold_seen;
    gap_left  = 0;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_id != hold_seen) begin
        hold_left = hold_req;
        hold_seen = hold_id;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        out_ch.ready <= 1'b0;
        gap_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!steady && $urandom_range(0, 5) == 0) gap_left = pick_gap();
      end
    end
  end

  task automatic send_item(input logic [KindW-1:0] k, input logic [31:0] s,
                           input logic [8:0] lab, input logic [16:0] ovl);
    int gap;
    gap = (!steady && $urandom_range(0, 99) < 25) ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= k;
    in_ch.score         <= s;
    in_ch.truth_label   <= lab;
    in_ch.truth_overlap <= ovl;
    do @(posedge clk_i); while (!in_ch.ready);
    if (k != KIND_UNUSED) items_sent++;
  endtask

  task automatic send_finish();
    send_item(KIND_FINISH, $urandom, $urandom, $urandom);
  endtask

  // sender waits until every report is back, then lets the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (reports_pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic obj, input logic en, input int ign, input int thr);
    cur_obj    = obj;
    cur_ign_en = en;
    cur_ign    = 9'(ign);
    cur_thr    = 17'(thr);
    write_reg(REG_OBJECTNESS, {31'b0, obj});
    write_reg(REG_IGN_EN, {31'b0, en});
    write_reg(REG_IGN_VALUE, {23'b0, cur_ign});
    write_reg(REG_BG_THRESH, {15'b0, cur_thr});
  endtask

  task automatic send_location(input int n_scores);
    int                hot;
    int                mode;
    int                r;
    int                ov;
    logic signed [31:0] s;
    logic [8:0]         lab;
    hot  = (n_scores > 0) ? $urandom_range(0, n_scores - 1) : 0;
    mode = $urandom_range(0, 2);
    for (int i = 0; i < n_scores; i++) begin
      case (mode)
        0: s = $urandom_range(0, 3);   // narrow range, lots of ties
        1: s = $urandom;
        default: s = (i == hot) ? 32'sd300000 + $urandom_range(0, 9999)
                                : $urandom_range(0, 199999) - 100000;
      endcase
      send_item(KIND_SCORE, s, $urandom, $urandom);
      if ($urandom_range(0, 49) == 0) send_item(KIND_UNUSED, $urandom, $urandom, $urandom);
    end
    // broken sequence: report lands in the middle of a location
    if ($urandom_range(0, 19) == 0) send_finish();

    r = $urandom_range(0, 99);
    if (r < 40) lab = 9'(hot);
    else if (r < 55) lab = 9'd0;
    else if (r < 65) lab = cur_ign;
    else if (r < 72) lab = 9'h1FF;
    else lab = $urandom_range(0, 255);

    r = $urandom_range(0, 9);
    if (r < 5) ov = $urandom_range(0, 65536);
    else if (r < 8) ov = (cur_thr == 0) ? $urandom_range(0, 1)
                                        : int'(cur_thr) - 1 + $urandom_range(0, 2);
    else ov = (r == 8) ? 0 : 65536;
    if (ov > 65536) ov = 65536;
    send_item(KIND_CLOSE, $urandom, lab, 17'(ov));
  endtask

  task automatic run_phase(input int budget);
    int first;
    first = items_sent;
    while (items_sent - first < budget) begin
      send_location(pick_class_count());
      if ($urandom_range(0, 3) == 0) send_finish();
    end
    send_finish();
    drain();
  endtask

  initial begin
    items_sent  = 0;
    hold_req    = 0;
    hold_id     = 0;
    phase       = 0;
    steady      = 1'b1;
    cur_obj     = 1'b0;
    cur_ign_en  = 1'b0;
    cur_ign     = -9'sd1;
    cur_thr     = 17'd32768;
    rst_ni              <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.kind          <= KIND_SCORE;
    in_ch.score         <= '0;
    in_ch.truth_label   <= '0;
    in_ch.truth_overlap <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, reset register values
    send_finish();                                    // both ratios empty
    send_item(KIND_CLOSE, '0, 9'h1FF, 17'd0);         // no score, label -1 hits
    send_item(KIND_SCORE, 32'd5, '0, '0);             // tie: first one wins
    send_item(KIND_SCORE, 32'd5, '0, '0);
    send_item(KIND_SCORE, 32'd3, '0, '0);
    send_item(KIND_CLOSE, '0, 9'd0, 17'd0);
    send_item(KIND_SCORE, 32'h8000_0000, '1, '1);
    send_item(KIND_SCORE, 32'h7FFF_FFFF, '1, '1);
    send_item(KIND_CLOSE, '1, 9'd1, 17'd65536);
    send_item(KIND_CLOSE, '0, 9'd0, 17'd32768);       // background at threshold
    send_item(KIND_CLOSE, '0, 9'd0, 17'd32767);       // just below, counted miss
    send_item(KIND_UNUSED, '1, '1, '1);
    send_item(KIND_SCORE, -32'sd7, '0, '0);
    send_finish();                                    // argmax survives the report
    send_item(KIND_CLOSE, '0, 9'd0, 17'd0);
    send_item(KIND_SCORE, 32'd1, '0, '0);
    send_item(KIND_CLOSE, '0, 9'd255, 17'd100);
    send_finish();
    drain();

    while (items_sent < ItemTarget || reports_seen < ReportTarget) begin
      phase++;
      case (phase)
        1: set_config(1'b0, 1'b1, -1, 0);
        2: set_config(1'b1, 1'b1, 255, 65536);
        3: set_config(1'b0, 1'b1, 0, 1);
        4: set_config(1'b1, 1'b0, 1, 32768);
        default: set_config($urandom_range(0, 1), $urandom_range(0, 1),
                            int'($urandom_range(0, 256)) - 1, $urandom_range(0, 65536));
      endcase
      steady = (phase % 4 == 3);
      if (phase == 1) begin
        // more scores than class slots; the late maximum must be dropped
        for (int i = 0; i < 260; i++)
          send_item(KIND_SCORE, (i < MaxClasses) ? 32'(i) : 32'h7FFF_FFFF, '0, '0);
        send_item(KIND_CLOSE, '0, 9'd255, 17'd0);
      end
      if (phase == 2) begin
        // long report stall while inputs keep coming
        send_location(3);
        hold_req = 400;
        hold_id++;
        send_finish();
        send_location(5);
        send_location(2);
        send_finish();                                // output full, input stalls
      end
      run_phase(130);
    end

    drain();
    repeat (40) @(posedge clk_i);
    $display("Run covered %0d transactions over %0d register settings, %0d reports checked",
             items_sent, phase + 1, reports_seen);
    $display("Included empty ratios, ties, score extremes, class overflow, skips and stalls");
    if (errors == 0) begin
      $display("tb_argmax_label_accuracy_counter OK");
    end else begin
      $display("tb_argmax_label_accuracy_counter NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/alac_pkg.sv
rtl/core/alac_if.sv
rtl/core/alac_div.sv
rtl/core/argmax_label_accuracy_counter.sv
dv/alac_checker.sv
dv/tb_argmax_label_accuracy_counter.sv
